/* hdl/nlsa_pkg.sv */
// Package for the n-gram log score accumulator.
// Field widths, reset values, register and mode codes, table control type.
// No dependencies.
`default_nettype none

package nlsa_pkg;

  localparam int ALPHABET_DEF   = 26;
  localparam int MAX_GRAM_DEF   = 4;
  localparam int VALUE_BITS_DEF = 16;

  localparam int LETTER_W = 5;
  localparam int INDEX_W  = 19;
  localparam int ENTRY_W  = 16;
  localparam int SCORE_W  = 40;
  localparam int COUNT_W  = 20;
  localparam int GLEN_W   = 3;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRAM_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASELINE    = 1'd1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_SCORE = 1'b1;

  localparam logic [GLEN_W-1:0]         GRAM_LENGTH_RST = 3'd4;
  localparam logic signed [ENTRY_W-1:0] BASELINE_RST    = -16'sd20480;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic [COUNT_W-1:0]        COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic rd;
    logic wr;
  } tbl_ctrl_t;

endpackage

`default_nettype wire

/* hdl/nlsa_gram_table.sv */
// Gram table: single-port synchronous RAM with registered read data.
// Uses nlsa_pkg::tbl_ctrl_t for the access control.
`default_nettype none

module nlsa_gram_table #(
  parameter int DEPTH  = 456976,
  parameter int ADDR_W = 19,
  parameter int DATA_W = 16
) (
  input  wire                      clk_i,
  input  wire  nlsa_pkg::tbl_ctrl_t ctrl_i,
  input  wire  [ADDR_W-1:0]        addr_i,
  input  wire  signed [DATA_W-1:0] wdata_i,
  output logic signed [DATA_W-1:0] rdata_o
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/ngram_log_score_accumulator.sv */
// Top level of the n-gram log score accumulator.
// Depends on nlsa_pkg and nlsa_gram_table.
`default_nettype none

// Takes one beat per cycle while the input is not stalled, loads and letters
// alike. A beat is indexed in the cycle it is accepted, is registered into the
// table stage, which touches the gram table (write for a load, read for a
// letter), and is then summed into the score in the summing stage, from which
// the result of a last letter goes into the output register. Loads and reads
// share the table's single port in acceptance order, so a load is seen by any
// letter accepted after it. The input stalls only while a result sits in the
// summing stage and the output register still holds an untaken result.
module ngram_log_score_accumulator #(
  parameter int ALPHABET   = nlsa_pkg::ALPHABET_DEF,
  parameter int MAX_GRAM   = nlsa_pkg::MAX_GRAM_DEF,
  parameter int VALUE_BITS = nlsa_pkg::VALUE_BITS_DEF
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    cfg_we_i,
  input  wire  [nlsa_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire  [nlsa_pkg::CFG_W-1:0]             cfg_wdata_i,
  input  wire                                    in_valid_i,
  output logic                                   in_stall_o,
  input  wire                                    mode_i,
  input  wire  [nlsa_pkg::LETTER_W-1:0]          letter_i,
  input  wire  [nlsa_pkg::INDEX_W-1:0]           entry_index_i,
  input  wire  signed [nlsa_pkg::ENTRY_W-1:0]    entry_value_i,
  input  wire                                    last_i,
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output logic signed [nlsa_pkg::SCORE_W-1:0]    score_o,
  output logic [nlsa_pkg::COUNT_W-1:0]           gram_count_o
);

  localparam int DEPTH     = ALPHABET ** MAX_GRAM;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int LET_W     = $clog2(ALPHABET);
  localparam int WIN_DEPTH = (MAX_GRAM > 1) ? MAX_GRAM - 1 : 1;
  localparam int SEEN_W    = $clog2(WIN_DEPTH + 1);
  localparam int SW        = nlsa_pkg::SCORE_W;
  localparam int CW        = nlsa_pkg::COUNT_W;
  localparam logic [nlsa_pkg::GLEN_W-1:0] MAX_G = nlsa_pkg::GLEN_W'(MAX_GRAM);

  // configuration
  logic [nlsa_pkg::GLEN_W-1:0]         glen_q;
  logic signed [nlsa_pkg::ENTRY_W-1:0] baseline_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glen_q     <= nlsa_pkg::GRAM_LENGTH_RST;
      baseline_q <= nlsa_pkg::BASELINE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nlsa_pkg::REG_GRAM_LENGTH: glen_q     <= cfg_wdata_i[nlsa_pkg::GLEN_W-1:0];
        nlsa_pkg::REG_BASELINE:    baseline_q <= signed'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // handshake and advance
  logic adv;
  logic acc;
  logic b_valid_q, b_gram_q, b_last_q;
  logic out_valid_q;

  assign adv        = !(b_valid_q && b_last_q && out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign acc        = in_valid_i && adv;

  // front stage: letter window and index
  logic [LET_W-1:0]  win_q [WIN_DEPTH];
  logic [SEEN_W-1:0] seen_q;
  logic [LET_W-1:0]  letter_c;
  logic [nlsa_pkg::GLEN_W-1:0] g_eff;
  logic [IDX_W-1:0]  gram_idx;
  logic              gram_c;
  logic              load_ok;

  always_comb begin
    if (int'(letter_i) >= ALPHABET) begin
      letter_c = LET_W'(ALPHABET - 1);
    end else begin
      letter_c = LET_W'(letter_i);
    end
    if (glen_q == '0) begin
      g_eff = nlsa_pkg::GLEN_W'(1);
    end else if (glen_q > MAX_G) begin
      g_eff = MAX_G;
    end else begin
      g_eff = glen_q;
    end
    gram_idx = IDX_W'(letter_c);
    for (int j = 0; j < WIN_DEPTH; j++) begin
      if ((j + 1) < int'(g_eff)) begin
        gram_idx = IDX_W'(gram_idx * IDX_W'(ALPHABET) + IDX_W'(win_q[j]));
      end
    end
    gram_c  = int'(seen_q) >= (int'(g_eff) - 1);
    load_ok = 32'(entry_index_i) < 32'(DEPTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        win_q[k] <= '0;
      end
      seen_q <= '0;
    end else if (acc && mode_i == nlsa_pkg::MODE_SCORE) begin
      if (last_i) begin
        for (int k = 0; k < WIN_DEPTH; k++) begin
          win_q[k] <= '0;
        end
        seen_q <= '0;
      end else begin
        win_q[0] <= letter_c;
        for (int k = 1; k < WIN_DEPTH; k++) begin
          win_q[k] <= win_q[k-1];
        end
        if (int'(seen_q) < WIN_DEPTH) begin
          seen_q <= seen_q + SEEN_W'(1);
        end
      end
    end
  end

  // table stage
  logic                         a_valid_q, a_score_q, a_gram_q, a_last_q, a_wr_q;
  logic [IDX_W-1:0]             a_addr_q;
  logic signed [VALUE_BITS-1:0] a_wdata_q;
  logic signed [VALUE_BITS-1:0] tbl_rdata;
  nlsa_pkg::tbl_ctrl_t          tbl_ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_score_q <= 1'b0;
      a_gram_q  <= 1'b0;
      a_last_q  <= 1'b0;
      a_wr_q    <= 1'b0;
    end else if (adv) begin
      a_valid_q <= acc;
      a_score_q <= mode_i == nlsa_pkg::MODE_SCORE;
      a_gram_q  <= mode_i == nlsa_pkg::MODE_SCORE && gram_c;
      a_last_q  <= mode_i == nlsa_pkg::MODE_SCORE && last_i;
      a_wr_q    <= mode_i == nlsa_pkg::MODE_LOAD && load_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_addr_q  <= (mode_i == nlsa_pkg::MODE_SCORE) ? gram_idx : IDX_W'(entry_index_i);
      a_wdata_q <= VALUE_BITS'(entry_value_i);
    end
  end

  assign tbl_ctrl.rd = adv && a_valid_q && a_gram_q;
  assign tbl_ctrl.wr = adv && a_valid_q && a_wr_q;

  nlsa_gram_table #(
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W),
    .DATA_W (VALUE_BITS)
  ) u_table (
    .clk_i   (clk_i),
    .ctrl_i  (tbl_ctrl),
    .addr_i  (a_addr_q),
    .wdata_i (a_wdata_q),
    .rdata_o (tbl_rdata)
  );

  // summing stage
  logic signed [SW-1:0] sum_q;
  logic [CW-1:0]        count_q;
  logic signed [SW:0]   sum_wide;
  logic signed [SW-1:0] sum_nxt;
  logic [CW-1:0]        count_nxt;
  logic signed [SW-1:0] out_score_q;
  logic [CW-1:0]        out_count_q;

  always_comb begin
    if (tbl_rdata == '0) begin
      sum_wide = (SW+1)'(sum_q) + (SW+1)'(baseline_q);
    end else begin
      sum_wide = (SW+1)'(sum_q) + (SW+1)'(tbl_rdata);
    end
    sum_nxt   = sum_q;
    count_nxt = count_q;
    if (b_gram_q) begin
      if (sum_wide[SW] != sum_wide[SW-1]) begin
        sum_nxt = sum_wide[SW] ? nlsa_pkg::SCORE_MIN : nlsa_pkg::SCORE_MAX;
      end else begin
        sum_nxt = sum_wide[SW-1:0];
      end
      if (count_q != nlsa_pkg::COUNT_MAX) begin
        count_nxt = count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_gram_q  <= 1'b0;
      b_last_q  <= 1'b0;
      sum_q     <= '0;
      count_q   <= '0;
    end else if (adv) begin
      b_valid_q <= a_valid_q;
      b_gram_q  <= a_valid_q && a_gram_q;
      b_last_q  <= a_valid_q && a_score_q && a_last_q;
      if (b_valid_q && b_last_q) begin
        sum_q   <= '0;
        count_q <= '0;
      end else if (b_valid_q) begin
        sum_q   <= sum_nxt;
        count_q <= count_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && b_valid_q && b_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && b_valid_q && b_last_q) begin
      out_score_q <= sum_nxt;
      out_count_q <= count_nxt;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign score_o      = out_score_q;
  assign gram_count_o = out_count_q;

  // a new result only comes from a last letter in the summing stage
  a_rise_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(b_valid_q && b_last_q))
    else $error("result raised without a last letter");

  // input stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (b_valid_q && b_last_q && out_valid_q))
    else $error("input stalled without a blocked result");

  // text state cleared after a result is taken into the output register
  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && b_valid_q && b_last_q) |=> (sum_q == '0 && count_q == '0))
    else $error("score state not cleared after result");

  // table is never read and written in the same cycle
  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tbl_ctrl.rd && tbl_ctrl.wr))
    else $error("table read and write together");

  // letter count never passes the window depth
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(seen_q) <= WIN_DEPTH)
    else $error("letter count out of range");

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for ngram_log_score_accumulator.
// Loads gram tables and scores letter texts; a clocked predictor and a result queue
// check every score. Depends on nlsa_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nlsa_pkg::*;

  localparam int TABLE_DEPTH = ALPHABET_DEF ** MAX_GRAM_DEF;
  localparam int PER_PHASE   = 125;
  localparam int N_SETTINGS  = 9;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic                      mode;
    logic [LETTER_W-1:0]       letter;
    logic [INDEX_W-1:0]        idx;
    logic signed [ENTRY_W-1:0] value;
    logic                      last;
    bit                        hold;
  } beat_t;

  typedef struct packed {
    logic [2:0][LETTER_W-1:0]  win;
    logic [1:0]                seen;
    logic signed [SCORE_W-1:0] sum;
    logic [COUNT_W-1:0]        count;
  } text_t;

  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic [COUNT_W-1:0]        count;
  } total_t;

  typedef enum {STALL_NONE, STALL_ALTERNATE, STALL_RANDOM, STALL_HEAVY} stall_style_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = MODE_LOAD;
  logic [LETTER_W-1:0] letter = '0;
  logic [INDEX_W-1:0] entry_index = '0;
  logic signed [ENTRY_W-1:0] entry_value = '0;
  logic text_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SCORE_W-1:0] score;
  logic [COUNT_W-1:0] gram_count;

  ngram_log_score_accumulator uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (mode),
    .letter_i      (letter),
    .entry_index_i (entry_index),
    .entry_value_i (entry_value),
    .last_i        (text_last),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .score_o       (score),
    .gram_count_o  (gram_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  beat_t pending_beats[$];
  total_t awaited_totals[$];
  total_t want;
  beat_t next_beat;
  int errors = 0;
  int cycles = 0;
  int queued = 0;
  logic drained = 1'b1;

  // scoring model state
  bit signed [ENTRY_W-1:0] gram_values [TABLE_DEPTH];
  text_t text_now = '0;
  logic [GLEN_W-1:0] glen_now = GRAM_LENGTH_RST;
  logic signed [ENTRY_W-1:0] baseline_now = BASELINE_RST;

  // stimulus-side shadow, so no letter ever reads an unloaded entry
  bit gram_loaded [TABLE_DEPTH];
  text_t shadow_text = '0;
  int unsigned shadow_g = 4;
  logic [LETTER_W-1:0] favourites [4];

  function automatic int unsigned eff_glen(logic [GLEN_W-1:0] g);
    return (g == 0) ? 1 : (g > MAX_GRAM_DEF) ? MAX_GRAM_DEF : g;
  endfunction

  function automatic logic [LETTER_W-1:0] eff_letter(logic [LETTER_W-1:0] l);
    return (l >= ALPHABET_DEF) ? LETTER_W'(ALPHABET_DEF - 1) : l;
  endfunction

  // index of the gram closed by letter l, oldest letter least significant; -1 if none
  function automatic int gram_at(text_t t, int unsigned g, logic [LETTER_W-1:0] l);
    int idx;
    int j;
    if (t.seen < g - 1) return -1;
    idx = l;
    for (j = 0; j < g - 1; j++) idx = idx * ALPHABET_DEF + t.win[j];
    return idx;
  endfunction

  function automatic text_t push_letter(text_t t, logic [LETTER_W-1:0] l);
    t.win = {t.win[1:0], l};
    if (t.seen < 3) t.seen = t.seen + 1;
    return t;
  endfunction

  function automatic void apply_beat(logic m, logic [LETTER_W-1:0] l, logic [INDEX_W-1:0] idx,
                                     logic signed [ENTRY_W-1:0] val, logic fin);
    logic [LETTER_W-1:0] le;
    int gi;
    logic signed [ENTRY_W-1:0] v;
    longint acc;
    total_t t;
    if (m == MODE_LOAD) begin
      if (idx < TABLE_DEPTH) gram_values[idx] = val;
      return;
    end
    le = eff_letter(l);
    gi = gram_at(text_now, eff_glen(glen_now), le);
    if (gi >= 0) begin
      v = gram_values[gi];
      if (v == 0) v = baseline_now;
      acc = longint'($signed(text_now.sum)) + longint'(v);
      if (acc > SCORE_MAX) acc = SCORE_MAX;
      if (acc < SCORE_MIN) acc = SCORE_MIN;
      text_now.sum = acc[SCORE_W-1:0];
      if (text_now.count != COUNT_MAX) text_now.count = text_now.count + 1;
    end
    text_now = push_letter(text_now, le);
    if (fin) begin
      t.score = text_now.sum;
      t.count = text_now.count;
      awaited_totals.push_back(t);
      text_now = '0;
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_val);
    $display("%0t ns: %s: got %0d, wanted %0d", $realtime, what, got, exp_val);
    errors++;
  endtask

  function automatic logic signed [ENTRY_W-1:0] rand_entry();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'sh8000;
      2: return 16'sh7fff;
      default: return ENTRY_W'($urandom);
    endcase
  endfunction

  task automatic queue_load(int unsigned idx, logic signed [ENTRY_W-1:0] val);
    beat_t b;
    b.mode   = MODE_LOAD;
    b.letter = LETTER_W'($urandom);
    b.idx    = INDEX_W'(idx);
    b.value  = val;
    b.last   = $urandom_range(0, 1);
    b.hold   = 1'b0;
    if (idx < TABLE_DEPTH) gram_loaded[idx] = 1'b1;
    pending_beats.push_back(b);
    queued++;
  endtask

  task automatic queue_letter(logic [LETTER_W-1:0] l, logic fin, bit pause);
    beat_t b;
    int gi;
    gi = gram_at(shadow_text, shadow_g, eff_letter(l));
    if (gi >= 0 && !gram_loaded[gi]) queue_load(gi, rand_entry());
    b.mode   = MODE_SCORE;
    b.letter = l;
    b.idx    = INDEX_W'($urandom);
    b.value  = ENTRY_W'($urandom);
    b.last   = fin;
    b.hold   = pause;
    pending_beats.push_back(b);
    queued++;
    shadow_text = fin ? text_t'('0) : push_letter(shadow_text, eff_letter(l));
  endtask

  task automatic emit_texts(int n_items);
    int start;
    int len;
    int k;
    int j;
    int sel;
    int fav_idx;
    logic [LETTER_W-1:0] l;
    bit pause;
    start = queued;
    while ((queued - start) < n_items) begin
      sel = $urandom_range(0, 9);
      len = (sel < 7) ? $urandom_range(1, 12) : (sel < 9) ? $urandom_range(13, 40)
                                                         : $urandom_range(1, 3);
      pause = ($urandom_range(0, 30) == 0);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 5) == 0) begin
          sel = $urandom_range(0, 3);
          fav_idx = 0;
          for (j = 0; j < MAX_GRAM_DEF; j++)
            fav_idx = fav_idx * ALPHABET_DEF + favourites[$urandom_range(0, 3)];
          case (sel)
            0: queue_load($urandom_range(0, TABLE_DEPTH - 1), rand_entry());
            1: queue_load($urandom_range(0, ALPHABET_DEF ** shadow_g - 1), rand_entry());
            2: queue_load($urandom_range(TABLE_DEPTH, 2 ** INDEX_W - 1), rand_entry());
            default: queue_load(fav_idx, rand_entry());
          endcase
        end
        l = ($urandom_range(0, 4) == 0) ? LETTER_W'($urandom_range(0, 31))
                                        : favourites[$urandom_range(0, 3)];
        queue_letter(l, k == len - 1, pause && k == 0);
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // all beats taken, all results in, then let trailing loads clear the pipeline
  task automatic settle();
    do @(negedge clk); while (pending_beats.size() != 0 || in_valid || !drained);
    repeat (8) @(negedge clk);
  endtask

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() == 0 ||
                   (pending_beats[0].hold && (in_valid || !drained))) begin
        in_valid <= 1'b0;
      end else begin
        next_beat = pending_beats.pop_front();
        in_valid    <= 1'b1;
        mode        <= next_beat.mode;
        letter      <= next_beat.letter;
        entry_index <= next_beat.idx;
        entry_value <= next_beat.value;
        text_last   <= next_beat.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: stall style changes at random intervals
  stall_style_e stall_style = STALL_NONE;
  int style_left = 0;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      style_left <= 0;
    end else begin
      if (style_left == 0) begin
        stall_style <= stall_style_e'($urandom_range(0, 3));
        style_left  <= $urandom_range(50, 300);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        STALL_NONE:      out_stall <= 1'b0;
        STALL_ALTERNATE: out_stall <= ~out_stall;
        STALL_RANDOM:    out_stall <= ($urandom_range(0, 1) == 1);
        default:         out_stall <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  // monitor: config writes, accepted beats and results, all sampled at the edge
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      drained <= 1'b1;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_GRAM_LENGTH) glen_now = cfg_wdata[GLEN_W-1:0];
        else if (cfg_idx == REG_BASELINE) baseline_now = cfg_wdata;
      end
      if (in_valid && !in_stall) apply_beat(mode, letter, entry_index, entry_value, text_last);
      if (out_valid && !out_stall) begin
        if (awaited_totals.size() == 0) begin
          report_mismatch("result with no text pending", score, 0);
        end else begin
          want = awaited_totals.pop_front();
          if (score !== want.score) report_mismatch("score", score, want.score);
          if (gram_count !== want.count) report_mismatch("gram count", gram_count, want.count);
        end
      end
      drained <= (awaited_totals.size() == 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t ns: timed out", $realtime);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  logic [GLEN_W-1:0] glen_plan [N_SETTINGS] = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd7, 3'd4, 3'd6, 3'd2};
  logic [CFG_W-1:0] base_plan [N_SETTINGS] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff,
                                               16'h0001, 16'h8000, 16'hc123, 16'h7fff, 16'h3a5c};

  initial begin : stimulus
    int p;
    int k;
    for (k = 0; k < 4; k++) favourites[k] = $urandom_range(0, 25);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_load(0, 16'sh7fff);
    queue_load(TABLE_DEPTH - 1, 16'sh8000);
    queue_load(2 ** INDEX_W - 1, 16'sh5555);
    queue_load(1, '0);
    queue_letter(5'd3, 1'b1, 1'b0);
    queue_letter(5'd0, 1'b0, 1'b1);
    queue_letter(5'd0, 1'b0, 1'b0);
    queue_letter(5'd0, 1'b0, 1'b0);
    queue_letter(5'd0, 1'b1, 1'b0);
    queue_letter(5'd25, 1'b0, 1'b0);
    queue_letter(5'd31, 1'b0, 1'b0);
    queue_letter(5'd25, 1'b0, 1'b0);
    queue_letter(5'd25, 1'b0, 1'b0);
    queue_letter(5'd25, 1'b1, 1'b0);
    queue_letter(5'd1, 1'b0, 1'b0);
    queue_letter(5'd0, 1'b0, 1'b0);
    queue_letter(5'd0, 1'b0, 1'b0);
    queue_letter(5'd0, 1'b1, 1'b0);
    emit_texts(PER_PHASE);
    settle();

    for (p = 0; p < N_SETTINGS; p++) begin
      write_reg(REG_GRAM_LENGTH, {13'($urandom), glen_plan[p]});
      write_reg(REG_BASELINE, base_plan[p]);
      shadow_g = eff_glen(glen_plan[p]);
      for (k = 0; k < 4; k++) favourites[k] = $urandom_range(0, 25);
      @(negedge clk);
      emit_texts(PER_PHASE);
      settle();
    end

    if (awaited_totals.size() != 0)
      report_mismatch("results never delivered", awaited_totals.size(), 0);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
hdl/nlsa_pkg.sv
hdl/nlsa_gram_table.sv
hdl/ngram_log_score_accumulator.sv
test/testbench.sv
